### rtl/mfsp_pkg.sv
// Package: shared types and constants for the MIDI file stream parser.
`default_nettype none
package mfsp_pkg;

	localparam int MaxVlqBytes = 4;

	typedef enum logic [2:0] {
		K_HEADER  = 3'd0,
		K_TRK_ST  = 3'd1,
		K_CHAN    = 3'd2,
		K_SYS_ST  = 3'd3,
		K_PAYLOAD = 3'd4,
		K_TRK_END = 3'd5,
		K_DONE    = 3'd6,
		K_ERROR   = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE     = 3'd0,
		E_BAD_MTHD = 3'd1,
		E_SHORT    = 3'd2,
		E_BAD_MTRK = 3'd3,
		E_NO_RS    = 3'd4,
		E_BAD_ST   = 3'd5,
		E_LONG_NUM = 3'd6,
		E_EARLY    = 3'd7
	} err_t;

	typedef enum logic [4:0] {
		PH_HDR_ID, PH_HDR_LEN, PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV, PH_HDR_SKIP,
		PH_TRK_ID, PH_TRK_LEN, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
		PH_META_TYPE, PH_SYS_LEN, PH_PAYLOAD, PH_EOT_SKIP, PH_DONE, PH_ERROR
	} phase_t;

	localparam logic [31:0] IdMthd = 32'h4D546864;
	localparam logic [31:0] IdMtrk = 32'h4D54726B;
	localparam logic [7:0] MetaEot = 8'h2F;
	localparam logic [8:0] NegOne9 = 9'h1FF;

	// One result record, packed with the first field in the highest bits
	typedef struct packed {
		logic [2:0]  error_code;
		logic [15:0] header_format;
		logic [15:0] track_number;
		logic [31:0] length;
		logic [8:0]  aux;
		logic [8:0]  data2;
		logic [7:0]  data1;
		logic [4:0]  channel;
		logic [7:0]  status;
		logic [31:0] tick;
	} rec_t;

	localparam int RecW = $bits(rec_t);
	localparam int OutW = ((RecW + 7) / 8) * 8;

	// Up to two results caused by one request
	typedef struct packed {
		logic  two;
		kind_t k0;
		rec_t  r0;
		kind_t k1;
		rec_t  r1;
	} res_pair_t;

endpackage
`default_nettype wire

### rtl/mfsp_decode.sv
// Decode stage: parser state and per-byte result generation.
`default_nettype none
module mfsp_decode (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire logic               eos,
	input  wire logic [7:0]         b,
	output logic                    has_res,
	output mfsp_pkg::res_pair_t     res
);
	import mfsp_pkg::*;

	phase_t      ph_q, ph_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [31:0] acc_q, acc_n;
	logic [31:0] skip_q, skip_n;
	logic [15:0] ntrk_q, ntrk_n, cur_q, cur_n, fmt_q, fmt_n;
	logic [31:0] tick_q, tick_n;
	logic [7:0]  rs_q, rs_n, d1_q, d1_n;
	logic [8:0]  meta_q, meta_n;

	logic [2:0]  cnt_inc;
	logic [31:0] acc_fix, acc_vlq, skip_dec;
	logic        two_p;
	int          n;
	kind_t       ks [2];
	rec_t        rs [2];

	assign cnt_inc  = cnt_q + 3'd1;
	assign acc_fix  = {acc_q[23:0], b};
	assign acc_vlq  = {acc_q[24:0], b[6:0]};
	assign skip_dec = skip_q - 32'd1;
	assign two_p    = (rs_q[7:4] != 4'hC) && (rs_q[7:4] != 4'hD);

	// Next state and results for one request
	always_comb begin
		ph_n = ph_q; cnt_n = cnt_q; acc_n = acc_q; skip_n = skip_q;
		ntrk_n = ntrk_q; cur_n = cur_q; fmt_n = fmt_q; tick_n = tick_q;
		rs_n = rs_q; d1_n = d1_q; meta_n = meta_q;
		n = 0;
		ks[0] = K_HEADER; ks[1] = K_HEADER;
		rs[0] = '0; rs[1] = '0;
		if (ph_q != PH_DONE && ph_q != PH_ERROR) begin
			if (eos) begin
				ks[0] = K_ERROR; rs[0].error_code = E_EARLY; n = 1;
				ph_n = PH_ERROR;
			end else begin
				case (ph_q)
					PH_HDR_ID, PH_HDR_LEN, PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV,
					PH_TRK_ID, PH_TRK_LEN: begin
						acc_n = acc_fix; cnt_n = cnt_inc;
						if ((cnt_inc == 3'd4 && (ph_q == PH_HDR_ID || ph_q == PH_HDR_LEN
							|| ph_q == PH_TRK_ID || ph_q == PH_TRK_LEN))
							|| (cnt_inc == 3'd2 && (ph_q == PH_HDR_FMT
							|| ph_q == PH_HDR_NTRK || ph_q == PH_HDR_DIV))) begin
							cnt_n = '0; acc_n = '0;
							case (ph_q)
								PH_HDR_ID: begin
									if (acc_fix != IdMthd) begin
										ks[0] = K_ERROR; rs[0].error_code = E_BAD_MTHD;
										n = 1; ph_n = PH_ERROR;
									end else ph_n = PH_HDR_LEN;
								end
								PH_HDR_LEN: begin
									if (acc_fix < 32'd6) begin
										ks[0] = K_ERROR; rs[0].error_code = E_SHORT;
										n = 1; ph_n = PH_ERROR;
									end else begin
										skip_n = acc_fix - 32'd6; ph_n = PH_HDR_FMT;
									end
								end
								PH_HDR_FMT: begin
									fmt_n = acc_fix[15:0]; ph_n = PH_HDR_NTRK;
								end
								PH_HDR_NTRK: begin
									ntrk_n = acc_fix[15:0]; ph_n = PH_HDR_DIV;
								end
								PH_HDR_DIV: begin
									ks[0] = K_HEADER;
									rs[0].length = {16'd0, acc_fix[15:0]};
									rs[0].track_number = ntrk_q;
									rs[0].header_format = fmt_q;
									n = 1;
									if (skip_q == '0) begin
										if (cur_q == ntrk_q) begin
											ks[1] = K_DONE; n = 2; ph_n = PH_DONE;
										end else begin
											cur_n = cur_q + 16'd1; ph_n = PH_TRK_ID;
										end
									end else ph_n = PH_HDR_SKIP;
								end
								PH_TRK_ID: begin
									if (acc_fix != IdMtrk) begin
										ks[0] = K_ERROR; rs[0].error_code = E_BAD_MTRK;
										n = 1; ph_n = PH_ERROR;
									end else ph_n = PH_TRK_LEN;
								end
								default: begin
									tick_n = '0; rs_n = '0;
									ks[0] = K_TRK_ST; rs[0].length = acc_fix;
									rs[0].track_number = cur_q; n = 1;
									ph_n = PH_DELTA;
								end
							endcase
						end
					end
					PH_HDR_SKIP: begin
						skip_n = skip_dec;
						if (skip_dec == '0) begin
							cnt_n = '0; acc_n = '0;
							if (cur_q == ntrk_q) begin
								ks[0] = K_DONE; n = 1; ph_n = PH_DONE;
							end else begin
								cur_n = cur_q + 16'd1; ph_n = PH_TRK_ID;
							end
						end
					end
					PH_DELTA, PH_SYS_LEN: begin
						acc_n = acc_vlq; cnt_n = cnt_inc;
						if (b[7] && cnt_inc >= 3'(MaxVlqBytes)) begin
							ks[0] = K_ERROR; rs[0].error_code = E_LONG_NUM; n = 1;
							ph_n = PH_ERROR; cnt_n = '0; acc_n = '0;
						end else if (!b[7]) begin
							cnt_n = '0; acc_n = '0;
							if (ph_q == PH_DELTA) begin
								tick_n = tick_q + acc_vlq; ph_n = PH_STATUS;
							end else begin
								skip_n = acc_vlq;
								if (meta_q == {1'b0, MetaEot}) begin
									if (acc_vlq == '0) begin
										ks[0] = K_TRK_END; rs[0].tick = tick_q;
										rs[0].track_number = cur_q; n = 1;
										if (cur_q == ntrk_q) begin
											ks[1] = K_DONE; n = 2; ph_n = PH_DONE;
										end else begin
											cur_n = cur_q + 16'd1; ph_n = PH_TRK_ID;
										end
									end else ph_n = PH_EOT_SKIP;
								end else begin
									ks[0] = K_SYS_ST; rs[0].tick = tick_q;
									rs[0].status = rs_q; rs[0].aux = meta_q;
									rs[0].track_number = cur_q; rs[0].length = acc_vlq;
									n = 1;
									if (acc_vlq == '0) begin
										rs_n = '0; ph_n = PH_DELTA;
									end else ph_n = PH_PAYLOAD;
								end
							end
						end
					end
					PH_STATUS, PH_DATA1, PH_DATA2: begin
						if (ph_q == PH_STATUS && b[7]) begin
							rs_n = b; meta_n = NegOne9;
							if (b == 8'hFF) ph_n = PH_META_TYPE;
							else if (b == 8'hF0 || b == 8'hF7) ph_n = PH_SYS_LEN;
							else if (b > 8'hF0) begin
								ks[0] = K_ERROR; rs[0].error_code = E_BAD_ST; n = 1;
								ph_n = PH_ERROR;
							end else ph_n = PH_DATA1;
						end else if (ph_q == PH_STATUS && rs_q == '0) begin
							ks[0] = K_ERROR; rs[0].error_code = E_NO_RS; n = 1;
							ph_n = PH_ERROR;
						end else if (ph_q != PH_DATA2 && two_p) begin
							d1_n = b; ph_n = PH_DATA2;
						end else begin
							ks[0] = K_CHAN; rs[0].tick = tick_q;
							rs[0].status = {rs_q[7:4], 4'h0};
							rs[0].channel = {1'b0, rs_q[3:0]} + 5'd1;
							rs[0].data1 = (ph_q == PH_DATA2) ? d1_q : b;
							rs[0].data2 = (ph_q == PH_DATA2) ? {1'b0, b} : NegOne9;
							rs[0].track_number = cur_q; n = 1;
							ph_n = PH_DELTA;
						end
					end
					PH_META_TYPE: begin
						meta_n = {1'b0, b}; ph_n = PH_SYS_LEN;
					end
					PH_PAYLOAD: begin
						ks[0] = K_PAYLOAD; rs[0].tick = tick_q; rs[0].status = rs_q;
						rs[0].aux = meta_q; rs[0].track_number = cur_q;
						rs[0].data1 = b; n = 1;
						skip_n = skip_dec;
						if (skip_dec == '0) begin
							rs_n = '0; ph_n = PH_DELTA;
						end
					end
					PH_EOT_SKIP: begin
						skip_n = skip_dec;
						if (skip_dec == '0) begin
							ks[0] = K_TRK_END; rs[0].tick = tick_q;
							rs[0].track_number = cur_q; n = 1;
							if (cur_q == ntrk_q) begin
								ks[1] = K_DONE; n = 2; ph_n = PH_DONE;
							end else begin
								cur_n = cur_q + 16'd1; ph_n = PH_TRK_ID;
							end
						end
					end
					default: ph_n = PH_ERROR;
				endcase
			end
		end
		has_res   = (n != 0);
		res.two   = (n == 2);
		res.k0    = ks[0];
		res.r0    = rs[0];
		res.k1    = ks[1];
		res.r1    = rs[1];
	end

	// Hold parser state; advance on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR_ID; cnt_q <= '0; acc_q <= '0; skip_q <= '0;
			ntrk_q <= '0; cur_q <= '0; fmt_q <= '0; tick_q <= '0;
			rs_q <= '0; d1_q <= '0; meta_q <= NegOne9;
		end else if (fire) begin
			ph_q <= ph_n; cnt_q <= cnt_n; acc_q <= acc_n; skip_q <= skip_n;
			ntrk_q <= ntrk_n; cur_q <= cur_n; fmt_q <= fmt_n; tick_q <= tick_n;
			rs_q <= rs_n; d1_q <= d1_n; meta_q <= meta_n;
		end
	end

endmodule
`default_nettype wire

### rtl/mfsp_out.sv
// Output stage: result register that emits zero, one or two records per request.
`default_nettype none
module mfsp_out (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic                       has_res,
	input  wire mfsp_pkg::res_pair_t        res,
	output logic                            free,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [mfsp_pkg::OutW-1:0]       m_tdata,
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast
);
	import mfsp_pkg::*;

	logic [1:0]  cnt_q;
	res_pair_t   buf_q;
	logic        take;

	assign take     = m_tvalid && m_tready;
	// Accept a new request once the final held record leaves
	assign free     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser  = (cnt_q == 2'd2) ? buf_q.k0 : (buf_q.two ? buf_q.k1 : buf_q.k0);
	assign m_tlast  = (cnt_q == 2'd1);
	assign m_tdata  = OutW'((cnt_q == 2'd2 || !buf_q.two) ? buf_q.r0 : buf_q.r1);

	// Hold records until the receiver takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= has_res ? (res.two ? 2'd2 : 2'd1) : 2'd0;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && has_res) buf_q <= res;
	end

endmodule
`default_nettype wire

### rtl/midi_file_stream_parser_top.sv
// Top level of the MIDI file stream parser.
// Usage: file bytes enter on the s_ channel, one request per byte;
// s_tuser = 1 marks end of stream (byte ignored). Each request is decoded
// in the same cycle it is accepted and yields zero, one or two result
// records, held in an output register and sent on the m_ channel.
// m_tuser carries the record kind, m_tlast marks the final record of a
// request, m_tdata carries the remaining fields.
// m_tvalid rises in the cycle after a request that yields a record is accepted.
// One byte per cycle while each byte yields at most one record and the
// receiver is ready; a byte yielding two records holds the next byte off
// until both leave the single output register, one record per cycle.
// When the receiver stalls, s_tready drops as soon as the output register
// holds a record; otherwise a new byte is taken in the same cycle the last
// record leaves.
// Reset clears the parser to expect the header chunk and empties the output.
// After done or an error every byte is accepted and dropped until reset.
`default_nettype none
module midi_file_stream_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // byte_in
	input  wire logic        s_tuser,   // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [mfsp_pkg::OutW-1:0] m_tdata, // tick, status, channel, data1, data2,
	                                           // aux, length, track_number,
	                                           // header_format, error_code
	output logic [2:0]       m_tuser,   // kind
	output logic             m_tlast    // last
);
	import mfsp_pkg::*;

	logic      fire, has_res, free;
	res_pair_t res;

	assign s_tready = free;
	assign fire     = s_tvalid && free;

	mfsp_decode u_dec (
		.clk(clk), .arst_n(arst_n), .fire(fire), .eos(s_tuser), .b(s_tdata),
		.has_res(has_res), .res(res)
	);

	mfsp_out u_out (
		.clk(clk), .arst_n(arst_n), .load(fire), .has_res(has_res), .res(res),
		.free(free), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule
`default_nettype wire
